// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl of the heater sequencer
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ----- rtl/htps_pkg.sv -----
// types and constants for the heater time proportioning sequencer
// no dependencies; used by htps_cfg and the top level
package htps_pkg;

    localparam int POWER_W   = 7;
    localparam int TIME_W    = 16;
    localparam int TIMER_W   = 17;
    localparam int COUNT_W   = 32;
    localparam int PROD_W    = POWER_W + TIME_W;
    localparam int CFG_IDX_W = 2;
    localparam int MUL_W     = 24;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_USED_W  = 6 + 2 * COUNT_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POWER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;

    localparam logic [POWER_W-1:0] POWER_FULL = 7'd100;
    localparam logic [TIME_W-1:0]  PERIOD_MIN = 16'd100;
    localparam logic [TIME_W-1:0]  PERIOD_RST = 16'd1000;
    localparam logic [TIME_W-1:0]  WINDOW_RST = 16'd200;

    // x / 100 for x below 2^23: (x * ceil(2^30 / 100)) >> 30
    localparam logic [MUL_W-1:0] DIV100_MUL   = 24'd10737419;
    localparam int               DIV100_SHIFT = 30;

    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_ON   = 4'b0010,
        PH_OFF  = 4'b0100,
        PH_WIN  = 4'b1000
    } t_phase;

    localparam logic [1:0] CODE_IDLE = 2'd0;
    localparam logic [1:0] CODE_ON   = 2'd1;
    localparam logic [1:0] CODE_OFF  = 2'd2;
    localparam logic [1:0] CODE_WIN  = 2'd3;

    // derived timing handed from the config block to the sequencer
    typedef struct packed {
        logic [TIME_W-1:0] on_time;
        logic [TIME_W-1:0] off_time;
        logic [TIME_W-1:0] win_start;
        logic              win_fits;
        logic              hold_ticks;
        logic              settling;
    } t_timing;

    function automatic logic [1:0] phase_code(input t_phase p);
        logic [1:0] c;
        case (p)
            PH_IDLE: c = CODE_IDLE;
            PH_ON:   c = CODE_ON;
            PH_OFF:  c = CODE_OFF;
            PH_WIN:  c = CODE_WIN;
            default: c = CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/htps_cfg.sv -----
// configuration registers and derived on, off and window timing
// depends on htps_pkg and assert_macros.svh
`include "assert_macros.svh"
module htps_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [htps_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [htps_pkg::TIME_W-1:0]         i_cfg_data,
    output htps_pkg::t_timing                   o_timing
);
    import htps_pkg::*;

    logic [POWER_W-1:0]  r_power;
    logic [TIME_W-1:0]   r_period;
    logic [TIME_W-1:0]   r_window;
    logic [1:0]          r_settle;
    logic [PROD_W-1:0]   r_prod;
    logic [TIME_W-1:0]   r_quot;
    logic [TIME_W-1:0]   r_on;
    logic [TIME_W-1:0]   r_off;
    logic [TIME_W-1:0]   r_win_start;
    logic                r_win_fits;
    logic                r_hold;

    logic [PROD_W+MUL_W-1:0] w_mul;
    logic                    w_full;
    logic [TIME_W-1:0]       n_on;
    logic [TIME_W-1:0]       n_off;
    logic [POWER_W-1:0]      w_pow_in;

    assign w_pow_in = i_cfg_data[POWER_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power  <= POWER_FULL;
            r_period <= PERIOD_RST;
            r_window <= WINDOW_RST;
            r_settle <= 2'd3;
        end else begin
            if (i_cfg_we) begin
                r_settle <= 2'd3;
                case (i_cfg_idx)
                    REG_POWER:  r_power  <= (w_pow_in > POWER_FULL) ? POWER_FULL : w_pow_in;
                    REG_PERIOD: r_period <= (i_cfg_data < PERIOD_MIN) ? PERIOD_MIN : i_cfg_data;
                    REG_WINDOW: r_window <= i_cfg_data;
                    default: ;
                endcase
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    // period * power, then divide by 100 through a reciprocal multiply
    assign w_mul = (PROD_W+MUL_W)'(r_prod) * (PROD_W+MUL_W)'(DIV100_MUL);
    assign w_full = (r_power >= POWER_FULL);

    always_comb begin
        if (w_full) begin
            n_on  = (r_period > r_window) ? r_period - r_window : '0;
            n_off = r_window;
        end else begin
            n_on  = r_quot;
            n_off = r_period - r_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod      <= PROD_W'(r_period) * PROD_W'(r_power);
        r_quot      <= w_mul[DIV100_SHIFT +: TIME_W];
        r_on        <= n_on;
        r_off       <= n_off;
        r_win_fits  <= (r_window <= n_off);
        r_win_start <= n_off - r_window;
        r_hold      <= w_full && (r_window == '0);
    end

    assign o_timing = '{
        on_time:    r_on,
        off_time:   r_off,
        win_start:  r_win_start,
        win_fits:   r_win_fits,
        hold_ticks: r_hold,
        settling:   (r_settle != 2'd0)
    };

    `ASSERT_NEVER(a_power_range, i_clk, i_rst_n, r_power > POWER_FULL, "power above full")
    `ASSERT_NEVER(a_period_range, i_clk, i_rst_n, r_period < PERIOD_MIN, "period below minimum")
    `ASSERT_PROP(a_write_settles, i_clk, i_rst_n, i_cfg_we |=> r_settle == 2'd3, "settle not armed")

endmodule

// ----- rtl/heater_time_proportioning_sequencer_top.sv -----
// heater time proportioning sequencer: stream in, stream out, config port
// depends on htps_pkg, htps_cfg and assert_macros.svh
//
// Each input beat (a 1 ms tick or an enable event) gives exactly one result beat.
// A beat passes an input register, one stage of sequencer logic and a result
// register: one beat per clock when the output side keeps up and no configuration
// write is settling. The input side holds s_axis_tready low during a configuration
// write and while a settle counter, armed by the write or by reset, runs down, as the on
// and off times are recomputed through the period-times-power multiply and divide by 100.
`include "assert_macros.svh"
module heater_time_proportioning_sequencer_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [htps_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [htps_pkg::TIME_W-1:0]             i_cfg_data,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [htps_pkg::IN_TDATA_W-1:0]         s_axis_tdata,  // [0] enable_value
    input  logic                                    s_axis_tuser,  // [0] kind
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // [0] heater_on, [1] led_on, [3:2] phase, [4] phase_changed,
    // [5] measure_request, [37:6] cycle_count, [69:38] measure_count
    output logic [htps_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);
    import htps_pkg::*;

    t_timing w_timing;

    htps_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_timing   (w_timing)
    );

    logic                   r_in_valid;
    logic                   r_in_kind;
    logic                   r_in_en;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    t_phase                 r_phase,    n_phase;
    logic [TIMER_W-1:0]     r_timer,    n_timer;
    logic                   r_enabled,  n_enabled;
    logic                   r_heater,   n_heater;
    logic                   r_measured, n_measured;
    logic [COUNT_W-1:0]     r_cycles,   n_cycles;
    logic [COUNT_W-1:0]     r_measures, n_measures;
    logic                   n_req;

    logic                   w_adv;
    logic                   w_accept;
    logic [TIMER_W-1:0]     w_el;
    logic                   w_enter;
    logic                   w_done;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = (!r_in_valid || w_adv) && !w_timing.settling && !i_cfg_we;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_el    = (r_timer == TIMER_MAX) ? r_timer : r_timer + 1'b1;
    assign w_done  = (w_el >= {1'b0, w_timing.off_time});
    assign w_enter = !r_measured && w_timing.win_fits && (w_el >= {1'b0, w_timing.win_start});

    always_comb begin
        n_phase    = r_phase;
        n_timer    = r_timer;
        n_enabled  = r_enabled;
        n_heater   = r_heater;
        n_measured = r_measured;
        n_cycles   = r_cycles;
        n_measures = r_measures;
        n_req      = 1'b0;
        if (r_in_kind) begin
            if (r_in_en != r_enabled) begin
                n_enabled = r_in_en;
                if (r_in_en) begin
                    n_phase  = PH_ON;
                    n_timer  = '0;
                    n_heater = 1'b1;
                end else begin
                    if (r_phase != PH_IDLE) begin
                        n_phase = PH_IDLE;
                        n_timer = '0;
                    end
                    n_heater = 1'b0;
                end
            end
        end else begin
            n_timer = w_el;
            if (!r_enabled) begin
                if (r_phase != PH_IDLE) begin
                    n_phase  = PH_IDLE;
                    n_timer  = '0;
                    n_heater = 1'b0;
                end
            end else if (!w_timing.hold_ticks) begin
                case (r_phase)
                    PH_IDLE: begin
                        n_phase  = PH_ON;
                        n_timer  = '0;
                        n_heater = 1'b1;
                    end
                    PH_ON: begin
                        if (w_el >= {1'b0, w_timing.on_time}) begin
                            n_phase    = PH_OFF;
                            n_timer    = '0;
                            n_heater   = 1'b0;
                            n_measured = 1'b0;
                        end
                    end
                    PH_OFF: begin
                        // reaching the off time in the entry tick skips the window
                        if (w_done) begin
                            n_phase  = PH_ON;
                            n_timer  = '0;
                            n_heater = 1'b1;
                            n_cycles = r_cycles + 1'b1;
                        end else if (w_enter) begin
                            n_phase = PH_WIN;
                            n_timer = '0;
                        end
                    end
                    PH_WIN: begin
                        if (!r_measured) begin
                            n_req      = 1'b1;
                            n_measured = 1'b1;
                            n_measures = r_measures + 1'b1;
                        end
                        if (w_done) begin
                            n_phase  = PH_ON;
                            n_timer  = '0;
                            n_heater = 1'b1;
                            n_cycles = r_cycles + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_timer     <= '0;
            r_enabled   <= 1'b0;
            r_heater    <= 1'b0;
            r_measured  <= 1'b0;
            r_cycles    <= '0;
            r_measures  <= '0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv) begin
                r_phase    <= n_phase;
                r_timer    <= n_timer;
                r_enabled  <= n_enabled;
                r_heater   <= n_heater;
                r_measured <= n_measured;
                r_cycles   <= n_cycles;
                r_measures <= n_measures;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_kind <= s_axis_tuser;
            r_in_en   <= s_axis_tdata[0];
        end
        if (w_adv) begin
            r_out_data <= {
                (OUT_TDATA_W-OUT_USED_W)'(0),
                n_measures,
                n_cycles,
                n_req,
                (n_phase != r_phase),
                phase_code(n_phase),
                n_enabled && n_heater,
                n_heater
            };
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `ASSERT_PROP(a_heater_tracks_on, i_clk, i_rst_n,
        r_heater == (r_phase == PH_ON), "heater and phase disagree")
    `ASSERT_NEVER(a_disabled_idle, i_clk, i_rst_n,
        !r_enabled && r_phase != PH_IDLE, "disabled but not idle")
    `ASSERT_PROP(a_req_counted, i_clk, i_rst_n,
        (w_adv && n_req) |=> r_measures == $past(r_measures) + 1'b1, "request not counted")

endmodule
